// ===== rtl/rgbhsv_pkg.sv =====
// rgbhsv_pkg: shared types and constants for the rgb to hsv converter
`default_nettype none

package rgbhsv_pkg;

  // field widths
  localparam int CHAN_W  = 8;
  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;

  // divider geometry: quotients stay below 2**DIV_STEPS
  localparam int DIV_STEPS = 9;
  localparam int REM_W     = 17;
  localparam int QUO_W     = DIV_STEPS;
  localparam int QIDX_W    = $clog2(QUO_W);

  // arithmetic constants
  localparam int PERCENT     = 100;
  localparam int SECTOR_DEG  = 60;
  localparam int GREEN_BASE  = 120;
  localparam int BLUE_BASE   = 240;
  localparam int FULL_CIRCLE = 360;

  // pipeline depth: pixel reg, max/min reg, divider regs, output reg
  localparam int NUM_STAGES = 2 + (DIV_STEPS + 1) + 1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } hsv_t;

  // which formula the hue takes
  typedef enum logic [1:0] {
    SEL_RED_POS,
    SEL_RED_NEG,
    SEL_GREEN,
    SEL_BLUE
  } hue_sel_t;

  // after max/min search
  typedef struct packed {
    pixel_t            pix;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] delta;
    hue_sel_t          sel;
  } extrema_t;

  // one divider stage: hue and saturation dividers side by side
  typedef struct packed {
    logic [REM_W-1:0]  hrem;
    logic [REM_W-1:0]  srem;
    logic [QUO_W-1:0]  hq;
    logic [QUO_W-1:0]  sq;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] mx;
    logic [PCT_W-1:0]  bri;
    logic              red_neg;
    logic              gray;
  } div_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_converter.sv =====
// rgb_to_hsv_converter: pipelined rgb pixel to hue/saturation/brightness
//
//   channel | dir | handshake                 | payload
//   pixel   | in  | pixel_valid / pixel_ready | pixel_t {red, green, blue}
//   hsv     | out | hsv_valid / hsv_ready     | hsv_t {hue, saturation, brightness}
//
// one pixel per clock sustained while the output is not held off; each pixel passes
// through 13 register stages loaded in turn from the accepting edge: the two
// restoring dividers take one quotient bit per stage over 9 stages, plus the
// input, max/min, divider load and output registers.
// reset clears the valid bits only; data registers are not reset.
// when the output transaction is held off the whole pipeline stalls in place.
`default_nettype none

module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   pixel_valid,
  output logic        pixel_ready,
  input  wire pixel_t pixel,
  output logic        hsv_valid,
  input  wire logic   hsv_ready,
  output hsv_t        hsv
);

  // pipeline control
  logic                  en;
  logic [NUM_STAGES-1:0] v;

  // stage registers
  pixel_t   s_pix;
  extrema_t s_ext;
  extrema_t s_ext_next;
  div_t     dstg      [DIV_STEPS+1];
  div_t     dstg_next [DIV_STEPS+1];
  hsv_t     hsv_next;

  // one restoring division step for both dividers at quotient bit j
  function automatic div_t div_step(input div_t d, input logic [QIDX_W-1:0] j);
    div_t             r;
    logic [REM_W-1:0] hsub;
    logic [REM_W-1:0] ssub;
    r    = d;
    hsub = {{(REM_W-CHAN_W){1'b0}}, d.delta} << j;
    ssub = {{(REM_W-CHAN_W){1'b0}}, d.mx} << j;
    if (d.hrem >= hsub) begin
      r.hrem  = d.hrem - hsub;
      r.hq[j] = 1'b1;
    end
    if (d.srem >= ssub) begin
      r.srem  = d.srem - ssub;
      r.sq[j] = 1'b1;
    end
    return r;
  endfunction

  // global advance: move when the output slot is free or being taken
  assign en          = !v[NUM_STAGES-1] || hsv_ready;
  assign pixel_ready = en;
  assign hsv_valid   = v[NUM_STAGES-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NUM_STAGES-2:0], pixel_valid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      s_pix <= pixel;
    end
  end

  // max, min, delta and hue formula select
  always_comb begin
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    mx = s_pix.red;
    if (s_pix.green > mx) mx = s_pix.green;
    if (s_pix.blue > mx)  mx = s_pix.blue;
    mn = s_pix.red;
    if (s_pix.green < mn) mn = s_pix.green;
    if (s_pix.blue < mn)  mn = s_pix.blue;
    s_ext_next.pix   = s_pix;
    s_ext_next.mx    = mx;
    s_ext_next.delta = mx - mn;
    if (mx == s_pix.red) begin
      s_ext_next.sel = (s_pix.green >= s_pix.blue) ? SEL_RED_POS : SEL_RED_NEG;
    end else if (mx == s_pix.green) begin
      s_ext_next.sel = SEL_GREEN;
    end else begin
      s_ext_next.sel = SEL_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_ext <= s_ext_next;
    end
  end

  // numerators, brightness and divider load
  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] g;
    logic [REM_W-1:0] b;
    logic [REM_W-1:0] d;
    logic [REM_W-1:0] m100;
    logic [REM_W-1:0] bq;
    r    = REM_W'(s_ext.pix.red);
    g    = REM_W'(s_ext.pix.green);
    b    = REM_W'(s_ext.pix.blue);
    d    = REM_W'(s_ext.delta);
    m100 = REM_W'(s_ext.mx) * REM_W'(PERCENT);
    // divide by 255 through a reciprocal with carry correction
    bq   = (m100 + (m100 >> 8) + REM_W'(1)) >> 8;
    dstg_next[0] = '0;
    case (s_ext.sel)
      SEL_RED_POS: dstg_next[0].hrem = REM_W'(SECTOR_DEG) * (g - b);
      SEL_RED_NEG: dstg_next[0].hrem = REM_W'(SECTOR_DEG) * (b - g);
      SEL_GREEN:   dstg_next[0].hrem = REM_W'(GREEN_BASE) * d
                                     + REM_W'(SECTOR_DEG) * b
                                     - REM_W'(SECTOR_DEG) * r;
      SEL_BLUE:    dstg_next[0].hrem = REM_W'(BLUE_BASE) * d
                                     + REM_W'(SECTOR_DEG) * r
                                     - REM_W'(SECTOR_DEG) * g;
      default:     dstg_next[0].hrem = '0;
    endcase
    dstg_next[0].srem    = d * REM_W'(PERCENT);
    dstg_next[0].delta   = s_ext.delta;
    dstg_next[0].mx      = s_ext.mx;
    dstg_next[0].bri     = bq[PCT_W-1:0];
    dstg_next[0].red_neg = (s_ext.sel == SEL_RED_NEG);
    dstg_next[0].gray    = (s_ext.delta == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dstg[0] <= dstg_next[0];
    end
  end

  // divider stages, msb of the quotient first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_comb begin
      dstg_next[k+1] = div_step(dstg[k], QIDX_W'(DIV_STEPS - 1 - k));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dstg[k+1] <= dstg_next[k+1];
      end
    end
  end

  // final hue wrap and gray cleanup
  always_comb begin
    div_t d;
    d = dstg[DIV_STEPS];
    hsv_next.brightness = d.bri;
    if (d.gray) begin
      hsv_next.hue        = '0;
      hsv_next.saturation = '0;
    end else begin
      hsv_next.saturation = d.sq[PCT_W-1:0];
      if (d.red_neg) begin
        hsv_next.hue = (d.hq == '0) ? '0 : HUE_W'(FULL_CIRCLE) - d.hq;
      end else begin
        hsv_next.hue = d.hq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsv <= hsv_next;
    end
  end

`ifndef NO_ASSERTIONS
  // hue wraps into one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.hue < HUE_W'(FULL_CIRCLE)))
    else $error("hue out of range");

  // both percentages stay within full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.saturation <= PCT_W'(PERCENT)) &&
                  (hsv.brightness <= PCT_W'(PERCENT)))
    else $error("percentage out of range");

  // a stall freezes every valid bit in the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for the rgb to hsv converter
module tb_top;
  import rgbhsv_pkg::*;

  // expected hsv transactions, predicted from each accepted pixel
  class hsv_scoreboard;
    hsv_t        expected_hsv[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // exact integer hue/saturation/brightness of one pixel
    function hsv_t predict_hsv(pixel_t px);
      int   r, g, b, mx, mn, delta, h, s, m;
      hsv_t res;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      h = 0;
      s = 0;
      if (mx > 0) begin
        s = (delta * PERCENT) / mx;
        if (delta > 0) begin
          // ties pick red, then green, then blue
          if (mx == r) begin
            if (g >= b) begin
              h = (SECTOR_DEG * (g - b)) / delta;
            end else begin
              // truncate toward zero, wrap only when still negative
              m = (SECTOR_DEG * (b - g)) / delta;
              h = (m > 0) ? FULL_CIRCLE - m : 0;
            end
          end else if (mx == g) begin
            h = (GREEN_BASE * delta + SECTOR_DEG * (b - r)) / delta;
          end else begin
            h = (BLUE_BASE * delta + SECTOR_DEG * (r - g)) / delta;
          end
        end
      end
      res.hue        = HUE_W'(h);
      res.saturation = PCT_W'(s);
      res.brightness = PCT_W'((mx * PERCENT) / ((1 << CHAN_W) - 1));
      return res;
    endfunction

    // accepted pixel transaction
    function void note_pixel(pixel_t px);
      expected_hsv.push_back(predict_hsv(px));
    endfunction

    // accepted hsv transaction, compared with the oldest prediction
    function void check_hsv(hsv_t got);
      hsv_t want;
      if (expected_hsv.size() == 0) begin
        $display("%0t: unexpected hsv transaction hue %0d sat %0d bri %0d",
                 $time, got.hue, got.saturation, got.brightness);
        errors++;
        return;
      end
      want = expected_hsv.pop_front();
      if (got.hue !== want.hue) begin
        $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $display("%0t: saturation expected %0d actual %0d",
                 $time, want.saturation, got.saturation);
        errors++;
      end
      if (got.brightness !== want.brightness) begin
        $display("%0t: brightness expected %0d actual %0d",
                 $time, want.brightness, got.brightness);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_hsv.size();
    endfunction
  endclass

  localparam int RANDOM_PIXELS = 1300;
  localparam int QUIET_TAIL    = 150;

  logic          clk;
  logic          rst;
  logic          pixel_valid;
  logic          pixel_ready;
  pixel_t        pixel;
  logic          hsv_valid;
  logic          hsv_ready;
  hsv_t          hsv;
  bit            quiet_phase;
  hsv_scoreboard sb;

  rgb_to_hsv_converter i_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hsv         (hsv)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic pixel_t make_pixel(int r, int g, int b);
    pixel_t px;
    px.red   = CHAN_W'(r);
    px.green = CHAN_W'(g);
    px.blue  = CHAN_W'(b);
    return px;
  endfunction

  // mostly uniform pixels, plus grays, ties, tiny values and near-zero red hues
  function automatic pixel_t random_pixel();
    int kind, a, c, pos;
    kind = $urandom_range(0, 9);
    case (kind)
      6: begin
        a = $urandom_range(0, 255);
        return make_pixel(a, a, a);
      end
      7: begin
        a = $urandom_range(1, 255);
        c = $urandom_range(0, a);
        pos = $urandom_range(0, 2);
        if (pos == 0) return make_pixel(c, a, a);
        else if (pos == 1) return make_pixel(a, c, a);
        else return make_pixel(a, a, c);
      end
      8: begin
        return make_pixel($urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 3));
      end
      9: begin
        a = $urandom_range(1, 255);
        c = $urandom_range(0, a - 1);
        return make_pixel(a, c, c + 1);
      end
      default: begin
        return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
      end
    endcase
  endfunction

  // one pixel transaction, optionally after an idle gap; starts and ends at negedge
  task automatic drive_pixel(input pixel_t px, input int unsigned gap);
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    do @(posedge clk); while (!pixel_ready);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  function automatic int unsigned sender_gap();
    if (quiet_phase || $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(1, 8);
  endfunction

  // receiver backpressure in bursts
  initial begin
    hsv_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_phase || $urandom_range(0, 5) != 0) begin
        hsv_ready <= 1'b1;
      end else begin
        hsv_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && hsv_valid && hsv_ready) sb.check_hsv(hsv);
  end

  // stimulus
  initial begin
    pixel_t corner_px[$];
    sb          = new();
    rst         = 1'b1;
    pixel_valid = 1'b0;
    pixel       = '0;
    quiet_phase = 1'b0;

    // extremes, pure colors, ties, black, gray and tiny negative red hues
    corner_px.push_back(make_pixel(0, 0, 0));
    corner_px.push_back(make_pixel(255, 255, 255));
    corner_px.push_back(make_pixel(128, 128, 128));
    corner_px.push_back(make_pixel(1, 1, 1));
    corner_px.push_back(make_pixel(255, 0, 0));
    corner_px.push_back(make_pixel(0, 255, 0));
    corner_px.push_back(make_pixel(0, 0, 255));
    corner_px.push_back(make_pixel(255, 255, 0));
    corner_px.push_back(make_pixel(0, 255, 255));
    corner_px.push_back(make_pixel(255, 0, 255));
    corner_px.push_back(make_pixel(255, 0, 1));
    corner_px.push_back(make_pixel(200, 10, 11));
    corner_px.push_back(make_pixel(255, 0, 5));
    corner_px.push_back(make_pixel(1, 0, 0));
    corner_px.push_back(make_pixel(0, 0, 1));
    corner_px.push_back(make_pixel(255, 254, 0));
    corner_px.push_back(make_pixel(254, 255, 0));
    corner_px.push_back(make_pixel(0, 1, 255));
    corner_px.push_back(make_pixel(85, 170, 255));
    corner_px.push_back(make_pixel(170, 85, 255));
    corner_px.push_back(make_pixel(255, 170, 85));
    corner_px.push_back(make_pixel(1, 0, 1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corner_px[i]) drive_pixel(corner_px[i], sender_gap());

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i >= RANDOM_PIXELS - QUIET_TAIL) quiet_phase = 1'b1;
      drive_pixel(random_pixel(), sender_gap());
    end
    pixel_valid <= 1'b0;

    // drain the pipeline
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rgbhsv_pkg.sv
rtl/rgb_to_hsv_converter.sv
tb/sv/tb_top.sv
